[hdl/sqtu_pkg.sv]
// ----------------------------------------------------------------------------
// sqtu_pkg: shared types and constants of the SARSA table update core
// Table geometry, register codes, the control word of the microcoded
// sequencer and the status that the datapath returns to it.
// ----------------------------------------------------------------------------
package sqtu_pkg;

	// Table geometry
	localparam int GRID_SIDE    = 8;
	localparam int ACTION_COUNT = 5;
	localparam int TABLE_DEPTH  = GRID_SIDE * GRID_SIDE * ACTION_COUNT;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	localparam int ROW_W        = $clog2(GRID_SIDE);

	// Field widths
	localparam int COORD_W  = 3;
	localparam int ACT_W    = 3;
	localparam int REWARD_W = 16;
	localparam int VALUE_W  = 32;
	localparam int FRAC_W   = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = CFG_IDX_W'(1);
	localparam logic [FRAC_W-1:0] LEARN_RATE_RST = FRAC_W'(6554);
	localparam logic [FRAC_W-1:0] DISCOUNT_RST   = FRAC_W'(58982);

	// Microcode program counter
	localparam int UPC_W = 4;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_CLR_MORE,
		COND_NO_INPUT,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		ASEL_CLR,
		ASEL_NEXT,
		ASEL_CUR,
		ASEL_CELL
	} asel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LD_QN,
		OP_LD_Q_MUL_G,
		OP_TD,
		OP_MUL_A,
		OP_NEWVAL,
		OP_CMP_INIT,
		OP_CMP
	} op_t;

	// One control word per microstep
	typedef struct packed {
		cond_t             cond;     // hold the step while true
		logic              jump;     // otherwise go to target instead of the next step
		logic [UPC_W-1:0]  target;
		logic              in_rdy;
		logic              out_ld;
		logic              mem_rd;
		logic              mem_we;
		asel_t             asel;
		logic [ACT_W-1:0]  act_off;
		op_t               op;
	} ucode_t;

	typedef struct packed {
		logic clr_more;
		logic out_busy;
	} dp_stat_t;

endpackage

[hdl/sqtu_useq.sv]
// ----------------------------------------------------------------------------
// sqtu_useq: microcode sequencer
// Step counter, read-only control program and the hold/jump logic.
// ----------------------------------------------------------------------------
module sqtu_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sqtu_pkg::dp_stat_t stat,
	output sqtu_pkg::ucode_t   ctrl
);

	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_CLR      = sqtu_pkg::UPC_W'(0);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_IDLE     = sqtu_pkg::UPC_W'(1);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_NEXT  = sqtu_pkg::UPC_W'(2);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_CUR   = sqtu_pkg::UPC_W'(3);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_MUL_G    = sqtu_pkg::UPC_W'(4);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_TD       = sqtu_pkg::UPC_W'(5);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_MUL_A    = sqtu_pkg::UPC_W'(6);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_NEWVAL   = sqtu_pkg::UPC_W'(7);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_WRITE    = sqtu_pkg::UPC_W'(8);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_A0    = sqtu_pkg::UPC_W'(9);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_A1    = sqtu_pkg::UPC_W'(10);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_A2    = sqtu_pkg::UPC_W'(11);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_A3    = sqtu_pkg::UPC_W'(12);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_RD_A4    = sqtu_pkg::UPC_W'(13);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_CMP_LAST = sqtu_pkg::UPC_W'(14);
	localparam logic [sqtu_pkg::UPC_W-1:0] UPC_OUT      = sqtu_pkg::UPC_W'(15);

	logic [sqtu_pkg::UPC_W-1:0] upc_q;
	logic                       cond_hit;

	// Control program
	always_comb begin
		ctrl = '0;
		case (upc_q)
			UPC_CLR: begin
				ctrl.cond   = sqtu_pkg::COND_CLR_MORE;
				ctrl.mem_we = 1'b1;
				ctrl.asel   = sqtu_pkg::ASEL_CLR;
			end
			UPC_IDLE: begin
				ctrl.cond   = sqtu_pkg::COND_NO_INPUT;
				ctrl.in_rdy = 1'b1;
			end
			UPC_RD_NEXT: begin
				ctrl.mem_rd = 1'b1;
				ctrl.asel   = sqtu_pkg::ASEL_NEXT;
			end
			UPC_RD_CUR: begin
				ctrl.mem_rd = 1'b1;
				ctrl.asel   = sqtu_pkg::ASEL_CUR;
				ctrl.op     = sqtu_pkg::OP_LD_QN;
			end
			UPC_MUL_G:  ctrl.op = sqtu_pkg::OP_LD_Q_MUL_G;
			UPC_TD:     ctrl.op = sqtu_pkg::OP_TD;
			UPC_MUL_A:  ctrl.op = sqtu_pkg::OP_MUL_A;
			UPC_NEWVAL: ctrl.op = sqtu_pkg::OP_NEWVAL;
			UPC_WRITE: begin
				ctrl.mem_we = 1'b1;
				ctrl.asel   = sqtu_pkg::ASEL_CUR;
			end
			UPC_RD_A0: begin
				ctrl.mem_rd  = 1'b1;
				ctrl.asel    = sqtu_pkg::ASEL_CELL;
				ctrl.act_off = sqtu_pkg::ACT_W'(0);
			end
			UPC_RD_A1: begin
				ctrl.mem_rd  = 1'b1;
				ctrl.asel    = sqtu_pkg::ASEL_CELL;
				ctrl.act_off = sqtu_pkg::ACT_W'(1);
				ctrl.op      = sqtu_pkg::OP_CMP_INIT;
			end
			UPC_RD_A2: begin
				ctrl.mem_rd  = 1'b1;
				ctrl.asel    = sqtu_pkg::ASEL_CELL;
				ctrl.act_off = sqtu_pkg::ACT_W'(2);
				ctrl.op      = sqtu_pkg::OP_CMP;
			end
			UPC_RD_A3: begin
				ctrl.mem_rd  = 1'b1;
				ctrl.asel    = sqtu_pkg::ASEL_CELL;
				ctrl.act_off = sqtu_pkg::ACT_W'(3);
				ctrl.op      = sqtu_pkg::OP_CMP;
			end
			UPC_RD_A4: begin
				ctrl.mem_rd  = 1'b1;
				ctrl.asel    = sqtu_pkg::ASEL_CELL;
				ctrl.act_off = sqtu_pkg::ACT_W'(4);
				ctrl.op      = sqtu_pkg::OP_CMP;
			end
			UPC_CMP_LAST: ctrl.op = sqtu_pkg::OP_CMP;
			UPC_OUT: begin
				ctrl.cond   = sqtu_pkg::COND_OUT_BUSY;
				ctrl.out_ld = 1'b1;
				ctrl.jump   = 1'b1;
				ctrl.target = UPC_IDLE;
			end
			default: begin
				ctrl.jump   = 1'b1;
				ctrl.target = UPC_IDLE;
			end
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			sqtu_pkg::COND_NONE:     cond_hit = 1'b0;
			sqtu_pkg::COND_CLR_MORE: cond_hit = stat.clr_more;
			sqtu_pkg::COND_NO_INPUT: cond_hit = !in_valid;
			sqtu_pkg::COND_OUT_BUSY: cond_hit = stat.out_busy;
			default:                 cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_CLR;
		end else if (cond_hit) begin
			upc_q <= upc_q;
		end else if (ctrl.jump) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + sqtu_pkg::UPC_W'(1);
		end
	end

endmodule

[hdl/sqtu_dpath.sv]
// ----------------------------------------------------------------------------
// sqtu_dpath: datapath of the SARSA table update core
// Action-value table, shared multiplier, rounding and saturation, greedy
// compare, configuration registers and the output register.
// ----------------------------------------------------------------------------
module sqtu_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sqtu_pkg::ucode_t                       ctrl,
	output sqtu_pkg::dp_stat_t                     stat,
	input  logic                                   in_valid,
	input  logic        [sqtu_pkg::COORD_W-1:0]    cell_row,
	input  logic        [sqtu_pkg::COORD_W-1:0]    cell_col,
	input  logic        [sqtu_pkg::ACT_W-1:0]      taken_action,
	input  logic signed [sqtu_pkg::REWARD_W-1:0]   reward_value,
	input  logic        [sqtu_pkg::COORD_W-1:0]    next_row,
	input  logic        [sqtu_pkg::COORD_W-1:0]    next_col,
	input  logic        [sqtu_pkg::ACT_W-1:0]      next_action,
	input  logic                                   cfg_we,
	input  logic        [sqtu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [sqtu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic signed [sqtu_pkg::VALUE_W-1:0]    updated_value,
	output logic        [sqtu_pkg::ACT_W-1:0]      greedy_action,
	output logic signed [sqtu_pkg::VALUE_W-1:0]    greedy_value
);

	localparam int AW    = sqtu_pkg::ADDR_W;
	localparam int VW    = sqtu_pkg::VALUE_W;
	localparam int CMP_W = ((sqtu_pkg::ROW_W > sqtu_pkg::COORD_W) ?
		sqtu_pkg::ROW_W : sqtu_pkg::COORD_W) + 1;
	localparam int TD_W  = 35;
	localparam int MB_W  = sqtu_pkg::FRAC_W + 1;
	localparam int PR_W  = 52;
	localparam int SH_W  = PR_W - sqtu_pkg::FRAC_W;
	localparam int SUM_W = SH_W + 1;

	function automatic logic [sqtu_pkg::ROW_W-1:0] clamp_coord(
		input logic [sqtu_pkg::COORD_W-1:0] v);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(v);
		if (ext >= CMP_W'(sqtu_pkg::GRID_SIDE))
			ext = CMP_W'(sqtu_pkg::GRID_SIDE - 1);
		return sqtu_pkg::ROW_W'(ext);
	endfunction

	function automatic logic [AW-1:0] cell_base(
		input logic [sqtu_pkg::COORD_W-1:0] row,
		input logic [sqtu_pkg::COORD_W-1:0] col);
		logic [AW-1:0] cell_idx;
		cell_idx = AW'(clamp_coord(row)) * AW'(sqtu_pkg::GRID_SIDE) + AW'(clamp_coord(col));
		return cell_idx * AW'(sqtu_pkg::ACTION_COUNT);
	endfunction

	function automatic logic [sqtu_pkg::ACT_W-1:0] clamp_act(
		input logic [sqtu_pkg::ACT_W-1:0] a);
		if (a >= sqtu_pkg::ACT_W'(sqtu_pkg::ACTION_COUNT))
			return sqtu_pkg::ACT_W'(sqtu_pkg::ACTION_COUNT - 1);
		return a;
	endfunction

	// Table
	logic [VW-1:0] mem [sqtu_pkg::TABLE_DEPTH];
	logic [VW-1:0] rdata_q;
	logic [AW-1:0] addr;
	logic [VW-1:0] wdata;
	logic [AW-1:0] clr_q;

	// Transition registers
	logic [AW-1:0]                       base_cur_q;
	logic [AW-1:0]                       addr_cur_q;
	logic [AW-1:0]                       addr_nxt_q;
	logic signed [sqtu_pkg::REWARD_W-1:0] reward_q;

	// Arithmetic
	logic [sqtu_pkg::FRAC_W-1:0] learn_rate_q;
	logic [sqtu_pkg::FRAC_W-1:0] discount_q;
	logic signed [VW-1:0]    qn_q;
	logic signed [VW-1:0]    q_q;
	logic signed [TD_W-1:0]  td_q;
	logic signed [PR_W-1:0]  prod_q;
	logic signed [VW-1:0]    nv_q;
	logic signed [TD_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [PR_W-1:0]  prod_rnd;
	logic signed [SH_W-1:0]  prod_sh;
	logic signed [TD_W-1:0]  td_n;
	logic signed [SUM_W-1:0] sum_n;
	logic signed [VW-1:0]    nv_n;

	// Greedy search
	logic [sqtu_pkg::ACT_W-1:0] rd_act_q;
	logic signed [VW-1:0]       best_q;
	logic [sqtu_pkg::ACT_W-1:0] best_a_q;

	logic out_valid_q;
	logic accept;

	assign accept = ctrl.in_rdy && in_valid;

	always_comb begin
		case (ctrl.asel)
			sqtu_pkg::ASEL_CLR:  addr = clr_q;
			sqtu_pkg::ASEL_NEXT: addr = addr_nxt_q;
			sqtu_pkg::ASEL_CUR:  addr = addr_cur_q;
			sqtu_pkg::ASEL_CELL: addr = base_cur_q + AW'(ctrl.act_off);
			default:             addr = addr_cur_q;
		endcase
	end

	assign wdata = (ctrl.asel == sqtu_pkg::ASEL_CLR) ? '0 : nv_q;

	always_ff @(posedge clk) begin
		if (ctrl.mem_we)
			mem[addr] <= wdata;
		if (ctrl.mem_rd)
			rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctrl.mem_we && ctrl.asel == sqtu_pkg::ASEL_CLR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign stat.clr_more = (clr_q != AW'(sqtu_pkg::TABLE_DEPTH - 1));
	assign stat.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= sqtu_pkg::LEARN_RATE_RST;
			discount_q   <= sqtu_pkg::DISCOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sqtu_pkg::CFG_LEARN_RATE: learn_rate_q <= cfg_data;
				sqtu_pkg::CFG_DISCOUNT:   discount_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_cur_q <= cell_base(cell_row, cell_col);
			addr_cur_q <= cell_base(cell_row, cell_col) + AW'(clamp_act(taken_action));
			addr_nxt_q <= cell_base(next_row, next_col) + AW'(clamp_act(next_action));
			reward_q   <= reward_value;
		end
	end

	// Shared multiplier: gamma * q_next first, then alpha * TD error
	always_comb begin
		if (ctrl.op == sqtu_pkg::OP_MUL_A) begin
			mul_a = td_q;
			mul_b = $signed({1'b0, learn_rate_q});
		end else begin
			mul_a = TD_W'(qn_q);
			mul_b = $signed({1'b0, discount_q});
		end
	end

	// Round half up: add half an LSB, keep the upper bits (floor)
	assign prod_rnd = prod_q + PR_W'(32768);
	assign prod_sh  = prod_rnd[PR_W-1:sqtu_pkg::FRAC_W];

	assign td_n = $signed({{(TD_W - sqtu_pkg::REWARD_W - 8){reward_q[sqtu_pkg::REWARD_W-1]}},
		reward_q, 8'b0}) + $signed(prod_sh[TD_W-1:0]) - TD_W'(q_q);

	assign sum_n = SUM_W'(q_q) + SUM_W'(prod_sh);

	always_comb begin
		if (sum_n[SUM_W-1:VW-1] == '0 || sum_n[SUM_W-1:VW-1] == '1)
			nv_n = sum_n[VW-1:0];
		else if (sum_n[SUM_W-1])
			nv_n = {1'b1, {(VW-1){1'b0}}};
		else
			nv_n = {1'b0, {(VW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_rd)
			rd_act_q <= ctrl.act_off;
		case (ctrl.op)
			sqtu_pkg::OP_LD_QN: qn_q <= rdata_q;
			sqtu_pkg::OP_LD_Q_MUL_G: begin
				q_q    <= rdata_q;
				prod_q <= mul_a * mul_b;
			end
			sqtu_pkg::OP_TD:     td_q   <= td_n;
			sqtu_pkg::OP_MUL_A:  prod_q <= mul_a * mul_b;
			sqtu_pkg::OP_NEWVAL: nv_q   <= nv_n;
			sqtu_pkg::OP_CMP_INIT: begin
				best_q   <= rdata_q;
				best_a_q <= rd_act_q;
			end
			sqtu_pkg::OP_CMP: begin
				// strict compare keeps the lowest action on ties
				if ($signed(rdata_q) > best_q) begin
					best_q   <= rdata_q;
					best_a_q <= rd_act_q;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld && !stat.out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_ld && !stat.out_busy) begin
			updated_value <= nv_q;
			greedy_action <= best_a_q;
			greedy_value  <= best_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/sarsa_q_table_update_core.sv]
// ----------------------------------------------------------------------------
// sarsa_q_table_update_core: SARSA action-value table update
// Grid-world Q table with a microcoded single-port update sequence.
// ----------------------------------------------------------------------------
// Each input transfer carries one transition (cell, action, Q8.8 reward,
// next cell, next action). The core applies q += alpha*(r + gamma*q' - q)
// in Q16.16 with round-half-up products and saturation, writes the new
// value back and returns one result transfer: the new value plus the
// greedy action and value of the updated cell, lowest action on ties.
// Coordinates and actions past the grid are clamped to the last one.
// Timing: after reset a clearing pass zeroes the table, one entry per
// cycle, during which in_ready stays low; configuration writes are
// taken at any time. After that each input transfer runs through the
// whole program, and the next input is taken only once the result has
// been loaded into the output register. The step sequence is set by
// the single table port (seven reads and one write per transition) and
// by the one multiplier that serves both products in turn. A result
// waits in the output register while the next transition is accepted
// and computed; the core only holds when a second result is ready
// before the first has been taken.
// ----------------------------------------------------------------------------
module sarsa_q_table_update_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic        [sqtu_pkg::COORD_W-1:0]    cell_row,
	input  logic        [sqtu_pkg::COORD_W-1:0]    cell_col,
	input  logic        [sqtu_pkg::ACT_W-1:0]      taken_action,
	input  logic signed [sqtu_pkg::REWARD_W-1:0]   reward_value,
	input  logic        [sqtu_pkg::COORD_W-1:0]    next_row,
	input  logic        [sqtu_pkg::COORD_W-1:0]    next_col,
	input  logic        [sqtu_pkg::ACT_W-1:0]      next_action,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [sqtu_pkg::VALUE_W-1:0]    updated_value,
	output logic        [sqtu_pkg::ACT_W-1:0]      greedy_action,
	output logic signed [sqtu_pkg::VALUE_W-1:0]    greedy_value,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic        [sqtu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [sqtu_pkg::CFG_DATA_W-1:0] cfg_data
);

	sqtu_pkg::ucode_t   ctrl;
	sqtu_pkg::dp_stat_t stat;

	// Sequencer: step counter and control program; it holds on the idle
	// step until a transfer arrives and on the result step while the
	// output register is still occupied.
	sqtu_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Datapath: table, multiplier, rounding, saturation and greedy search.
	sqtu_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.in_valid      (in_valid),
		.cell_row      (cell_row),
		.cell_col      (cell_col),
		.taken_action  (taken_action),
		.reward_value  (reward_value),
		.next_row      (next_row),
		.next_col      (next_col),
		.next_action   (next_action),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.updated_value (updated_value),
		.greedy_action (greedy_action),
		.greedy_value  (greedy_value)
	);

	// Ready only on the idle step of the program.
	assign in_ready = ctrl.in_rdy;

endmodule

[tb/tb_sarsa_q_table_update_core.sv]
// ----------------------------------------------------------------------------
// tb_sarsa_q_table_update_core: self-checking bench for the SARSA update core
// Drives transitions over valid/ready with random gaps and output stalls.
// Each accepted transition runs through an in-bench Q16.16 table model, and
// every result transfer is compared field by field with that prediction.
// Stimulus: a directed table, saturation climbs at full learning rate and
// discount, then random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_sarsa_q_table_update_core;

	localparam int CYCLE_LIMIT = 200000;
	// Register slots past the two real registers; writes there must be dropped
	localparam logic [sqtu_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = sqtu_pkg::CFG_IDX_W'(2);
	localparam logic [sqtu_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = sqtu_pkg::CFG_IDX_W'(3);
	localparam longint VALUE_MAX = 64'sd2147483647;
	localparam longint VALUE_MIN = -64'sd2147483648;

	typedef struct packed {
		logic        [sqtu_pkg::COORD_W-1:0]  cell_row;
		logic        [sqtu_pkg::COORD_W-1:0]  cell_col;
		logic        [sqtu_pkg::ACT_W-1:0]    act;
		logic signed [sqtu_pkg::REWARD_W-1:0] reward;
		logic        [sqtu_pkg::COORD_W-1:0]  next_row;
		logic        [sqtu_pkg::COORD_W-1:0]  next_col;
		logic        [sqtu_pkg::ACT_W-1:0]    next_act;
	} transition_t;

	typedef struct packed {
		logic signed [sqtu_pkg::VALUE_W-1:0] new_value;
		logic        [sqtu_pkg::ACT_W-1:0]   best_act;
		logic signed [sqtu_pkg::VALUE_W-1:0] best_value;
	} q_result_t;

	// One directed row: the transition plus an optional hand-written result
	typedef struct packed {
		transition_t trn;
		logic        typed;
		q_result_t   res;
	} directed_row_t;

	localparam q_result_t ALL_ZERO = '0;
	localparam q_result_t NONE     = '0;
	localparam int DIRECTED_COUNT = 18;

	// Fields: row, col, action, reward, next row, next col, next action
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// untouched table: zero reward gives all-zero results
		'{'{3'd0, 3'd0, 3'd0, 16'sh0000, 3'd0, 3'd0, 3'd0}, 1'b1, ALL_ZERO},
		'{'{3'd7, 3'd7, 3'd4, 16'sh0000, 3'd7, 3'd7, 3'd4}, 1'b1, ALL_ZERO},
		// action index past the last action clamps to action 4
		'{'{3'd3, 3'd3, 3'd7, 16'sh0000, 3'd3, 3'd3, 3'd7}, 1'b1, ALL_ZERO},
		// reward extremes
		'{'{3'd1, 3'd2, 3'd2, 16'sh7FFF, 3'd5, 3'd6, 3'd1}, 1'b0, NONE},
		'{'{3'd2, 3'd1, 3'd3, 16'sh8000, 3'd6, 3'd5, 3'd0}, 1'b0, NONE},
		'{'{3'd0, 3'd7, 3'd1, 16'sh0001, 3'd7, 3'd0, 3'd0}, 1'b0, NONE},
		// next cell is the one just written
		'{'{3'd7, 3'd0, 3'd0, 16'shFFFF, 3'd0, 3'd7, 3'd1}, 1'b0, NONE},
		// same cell and action on both sides: the old value feeds the target
		'{'{3'd1, 3'd2, 3'd2, 16'sh4000, 3'd1, 3'd2, 3'd2}, 1'b0, NONE},
		'{'{3'd1, 3'd2, 3'd0, 16'sh7FFF, 3'd1, 3'd2, 3'd2}, 1'b0, NONE},
		// negative entries next to zeros: greedy picks the first zero
		'{'{3'd2, 3'd1, 3'd0, 16'shFFFF, 3'd2, 3'd1, 3'd3}, 1'b0, NONE},
		'{'{3'd4, 3'd4, 3'd5, 16'sh5555, 3'd4, 3'd4, 3'd6}, 1'b0, NONE},
		'{'{3'd4, 3'd4, 3'd4, 16'shAAAA, 3'd4, 3'd4, 3'd5}, 1'b0, NONE},
		// fresh cell: five-way tie resolves to action 0
		'{'{3'd5, 3'd5, 3'd1, 16'sh0000, 3'd6, 3'd6, 3'd2}, 1'b1, ALL_ZERO},
		'{'{3'd6, 3'd3, 3'd2, 16'sh0100, 3'd1, 3'd2, 3'd0}, 1'b0, NONE},
		'{'{3'd3, 3'd6, 3'd4, 16'sh7FFF, 3'd3, 3'd6, 3'd4}, 1'b0, NONE},
		'{'{3'd3, 3'd6, 3'd3, 16'sh7FFF, 3'd3, 3'd6, 3'd4}, 1'b0, NONE},
		'{'{3'd7, 3'd7, 3'd4, 16'sh8000, 3'd2, 3'd1, 3'd3}, 1'b0, NONE},
		'{'{3'd0, 3'd0, 3'd2, 16'sh0080, 3'd4, 3'd4, 3'd7}, 1'b0, NONE}
	};

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_ready;
	logic        [sqtu_pkg::COORD_W-1:0]    cell_row;
	logic        [sqtu_pkg::COORD_W-1:0]    cell_col;
	logic        [sqtu_pkg::ACT_W-1:0]      taken_action;
	logic signed [sqtu_pkg::REWARD_W-1:0]   reward_value;
	logic        [sqtu_pkg::COORD_W-1:0]    next_row;
	logic        [sqtu_pkg::COORD_W-1:0]    next_col;
	logic        [sqtu_pkg::ACT_W-1:0]      next_action;
	logic                                   out_valid;
	logic                                   out_ready;
	logic signed [sqtu_pkg::VALUE_W-1:0]    updated_value;
	logic        [sqtu_pkg::ACT_W-1:0]      greedy_action;
	logic signed [sqtu_pkg::VALUE_W-1:0]    greedy_value;
	logic                                   cfg_we;
	logic        [sqtu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic        [sqtu_pkg::CFG_DATA_W-1:0] cfg_data;

	// Mirror of the action-value table and the two fractions
	logic signed [sqtu_pkg::VALUE_W-1:0] q_table [sqtu_pkg::TABLE_DEPTH];
	logic        [sqtu_pkg::FRAC_W-1:0]  alpha_frac;
	logic        [sqtu_pkg::FRAC_W-1:0]  gamma_frac;

	q_result_t pending_results [$];

	bit gaps_on;
	int error_count;
	int transitions_sent;
	int results_checked;
	int saturated_updates;
	int clamped_actions;
	int settings_used;
	int cycle_count;

	sarsa_q_table_update_core dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model --

	function automatic int unsigned cell_offset(input logic [sqtu_pkg::COORD_W-1:0] row,
			input logic [sqtu_pkg::COORD_W-1:0] col);
		int unsigned r;
		int unsigned c;
		r = int'(row);
		c = int'(col);
		if (r >= sqtu_pkg::GRID_SIDE)
			r = sqtu_pkg::GRID_SIDE - 1;
		if (c >= sqtu_pkg::GRID_SIDE)
			c = sqtu_pkg::GRID_SIDE - 1;
		return (r * sqtu_pkg::GRID_SIDE + c) * sqtu_pkg::ACTION_COUNT;
	endfunction

	function automatic int unsigned clamp_action(input logic [sqtu_pkg::ACT_W-1:0] act);
		int unsigned a;
		a = int'(act);
		if (a >= sqtu_pkg::ACTION_COUNT)
			a = sqtu_pkg::ACTION_COUNT - 1;
		return a;
	endfunction

	// Drop 16 fraction bits, rounding half up (floor after adding one half)
	function automatic longint round_frac(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	// Apply one SARSA step to the mirror table and return the expected result
	function automatic q_result_t apply_sarsa_update(input transition_t trn);
		int unsigned cur_base;
		int unsigned cur_idx;
		int unsigned nxt_idx;
		longint      q_old;
		longint      q_next;
		longint      alpha_l;
		longint      gamma_l;
		longint      target;
		longint      sum;
		q_result_t   res;
		cur_base = cell_offset(trn.cell_row, trn.cell_col);
		cur_idx  = cur_base + clamp_action(trn.act);
		nxt_idx  = cell_offset(trn.next_row, trn.next_col) + clamp_action(trn.next_act);
		if (trn.act >= sqtu_pkg::ACTION_COUNT || trn.next_act >= sqtu_pkg::ACTION_COUNT)
			clamped_actions++;
		// read q' before the write so a self-transition sees the old value
		q_old   = longint'(q_table[cur_idx]);
		q_next  = longint'(q_table[nxt_idx]);
		alpha_l = longint'(alpha_frac);
		gamma_l = longint'(gamma_frac);
		target  = longint'(trn.reward) * 256 + round_frac(q_next * gamma_l);
		sum     = q_old + round_frac((target - q_old) * alpha_l);
		if (sum > VALUE_MAX) begin
			res.new_value = VALUE_MAX[sqtu_pkg::VALUE_W-1:0];
			saturated_updates++;
		end else if (sum < VALUE_MIN) begin
			res.new_value = VALUE_MIN[sqtu_pkg::VALUE_W-1:0];
			saturated_updates++;
		end else begin
			res.new_value = sum[sqtu_pkg::VALUE_W-1:0];
		end
		q_table[cur_idx] = res.new_value;
		// strict compare keeps the lowest action on ties
		res.best_act   = '0;
		res.best_value = q_table[cur_base];
		for (int a = 1; a < sqtu_pkg::ACTION_COUNT; a++) begin
			if (q_table[cur_base + a] > res.best_value) begin
				res.best_value = q_table[cur_base + a];
				res.best_act   = sqtu_pkg::ACT_W'(a);
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------- stimulus --

	function automatic logic [sqtu_pkg::COORD_W-1:0] pick_coord();
		// favor a small corner so entries get revisited and build up
		if ($urandom_range(99) < 70)
			return sqtu_pkg::COORD_W'($urandom_range(1));
		return sqtu_pkg::COORD_W'($urandom_range(sqtu_pkg::GRID_SIDE - 1));
	endfunction

	function automatic logic [sqtu_pkg::ACT_W-1:0] pick_action();
		if ($urandom_range(99) < 85)
			return sqtu_pkg::ACT_W'($urandom_range(sqtu_pkg::ACTION_COUNT - 1));
		return sqtu_pkg::ACT_W'($urandom_range(7, sqtu_pkg::ACTION_COUNT));
	endfunction

	function automatic logic signed [sqtu_pkg::REWARD_W-1:0] pick_reward();
		case ($urandom_range(3))
			0: return sqtu_pkg::REWARD_W'($urandom);
			1: begin
				case ($urandom_range(4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return 16'sh0001;
					default: return 16'shFFFF;
				endcase
			end
			default: return sqtu_pkg::REWARD_W'($urandom_range(4095)) - 16'sd2048;
		endcase
	endfunction

	function automatic transition_t random_transition();
		transition_t trn;
		trn.cell_row = pick_coord();
		trn.cell_col = pick_coord();
		trn.act      = pick_action();
		trn.reward   = pick_reward();
		// half the time stay in the same cell
		if ($urandom_range(1)) begin
			trn.next_row = trn.cell_row;
			trn.next_col = trn.cell_col;
		end else begin
			trn.next_row = pick_coord();
			trn.next_col = pick_coord();
		end
		trn.next_act = pick_action();
		return trn;
	endfunction

	// Present one transition, hold it until the transfer, then predict
	task automatic send_transition(input transition_t trn, input logic use_typed,
			input q_result_t typed_res);
		q_result_t predicted;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 19) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		cell_row     = trn.cell_row;
		cell_col     = trn.cell_col;
		taken_action = trn.act;
		reward_value = trn.reward;
		next_row     = trn.next_row;
		next_col     = trn.next_col;
		next_action  = trn.next_act;
		in_valid     = 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = apply_sarsa_update(trn);
		transitions_sent++;
		pending_results.push_back(use_typed ? typed_res : predicted);
	endtask

	// Drop valid and hold off until every outstanding result has been taken
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_register(input logic [sqtu_pkg::CFG_IDX_W-1:0] idx,
			input logic [sqtu_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			sqtu_pkg::CFG_LEARN_RATE: alpha_frac = data;
			sqtu_pkg::CFG_DISCOUNT:   gamma_frac = data;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [sqtu_pkg::FRAC_W-1:0] alpha,
			input logic [sqtu_pkg::FRAC_W-1:0] gamma);
		set_register(sqtu_pkg::CFG_LEARN_RATE, alpha);
		set_register(sqtu_pkg::CFG_DISCOUNT, gamma);
		settings_used++;
	endtask

	// Self-loop on action 4 (with aliases 5..7) until the entry pins at a rail
	task automatic run_climb(input logic [sqtu_pkg::COORD_W-1:0] row,
			input logic [sqtu_pkg::COORD_W-1:0] col,
			input logic [sqtu_pkg::REWARD_W-1:0] lo, input logic [sqtu_pkg::REWARD_W-1:0] hi,
			input int count);
		transition_t trn;
		for (int i = 0; i < count; i++) begin
			trn.cell_row = row;
			trn.cell_col = col;
			trn.act      = sqtu_pkg::ACT_W'($urandom_range(7, sqtu_pkg::ACTION_COUNT - 1));
			trn.reward   = sqtu_pkg::REWARD_W'($urandom_range(hi, lo));
			trn.next_row = row;
			trn.next_col = col;
			trn.next_act = sqtu_pkg::ACT_W'($urandom_range(7, sqtu_pkg::ACTION_COUNT - 1));
			send_transition(trn, 1'b0, NONE);
		end
	endtask

	// Feed a saturated entry into other targets so they hit the rails at once
	task automatic run_spill(input logic [sqtu_pkg::COORD_W-1:0] row,
			input logic [sqtu_pkg::COORD_W-1:0] col,
			input logic [sqtu_pkg::REWARD_W-1:0] lo, input logic [sqtu_pkg::REWARD_W-1:0] hi,
			input int count);
		transition_t trn;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(1)) begin
				trn.cell_row = row;
				trn.cell_col = col;
				trn.act      = sqtu_pkg::ACT_W'($urandom_range(sqtu_pkg::ACTION_COUNT - 2));
			end else begin
				trn.cell_row = sqtu_pkg::COORD_W'($urandom_range(sqtu_pkg::GRID_SIDE - 1));
				trn.cell_col = sqtu_pkg::COORD_W'($urandom_range(sqtu_pkg::GRID_SIDE - 1));
				trn.act      = pick_action();
			end
			trn.reward   = sqtu_pkg::REWARD_W'($urandom_range(hi, lo));
			trn.next_row = row;
			trn.next_col = col;
			trn.next_act = sqtu_pkg::ACT_W'(sqtu_pkg::ACTION_COUNT - 1);
			send_transition(trn, 1'b0, NONE);
		end
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			// now and then let the pipeline empty out completely
			if ($urandom_range(39) == 0)
				wait_results_drained();
			send_transition(random_transition(), 1'b0, NONE);
		end
	endtask

	// ------------------------------------------------------------- checking --

	task automatic flag_mismatch(input string field, input longint want, input longint got);
		error_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Stall the result side at random, except during the gap-free stretch
	always @(negedge clk)
		out_ready <= !(gaps_on && $urandom_range(99) < 19);

	always @(posedge clk) begin : result_check
		q_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result transfer with nothing expected, value %0d",
					$time, updated_value);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (updated_value !== want.new_value)
					flag_mismatch("updated_value", longint'(want.new_value),
						longint'(updated_value));
				if (greedy_action !== want.best_act)
					flag_mismatch("greedy_action", longint'(want.best_act),
						longint'(greedy_action));
				if (greedy_value !== want.best_value)
					flag_mismatch("greedy_value", longint'(want.best_value),
						longint'(greedy_value));
			end
		end
	end

	// Hard stop: covers the clearing pass and the worst stall pattern many times
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------- sequence --

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cell_row     = '0;
		cell_col     = '0;
		taken_action = '0;
		reward_value = '0;
		next_row     = '0;
		next_col     = '0;
		next_action  = '0;
		out_ready    = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		gaps_on      = 1'b1;
		foreach (q_table[i])
			q_table[i] = '0;
		alpha_frac = sqtu_pkg::LEARN_RATE_RST;
		gamma_frac = sqtu_pkg::DISCOUNT_RST;
		settings_used = 1;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed table under reset settings; in_ready holds off the
		// first transfer until the clearing pass is over
		foreach (DIRECTED_ROWS[i])
			send_transition(DIRECTED_ROWS[i].trn, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].res);
		wait_results_drained();

		// Writes to unused slots must leave both fractions alone
		set_register(CFG_SPARE_LO, '0);
		set_register(CFG_SPARE_HI, '1);

		// Full alpha and gamma: drive one entry to each rail, then spill
		apply_settings('1, '1);
		run_climb(3'd6, 3'd2, 16'h7800, 16'h7FFF, 300);
		run_spill(3'd6, 3'd2, 16'h0000, 16'h7FFF, 20);
		run_climb(3'd1, 3'd5, 16'h8000, 16'h87FF, 300);
		run_spill(3'd1, 3'd5, 16'h8000, 16'hFFFF, 20);
		wait_results_drained();

		// Zero alpha and gamma: nothing may move
		apply_settings('0, '0);
		run_random(60);
		wait_results_drained();

		// Long stretch with no gaps on either side, random fractions
		gaps_on = 1'b0;
		apply_settings(sqtu_pkg::FRAC_W'($urandom), sqtu_pkg::FRAC_W'($urandom));
		run_random(180);
		wait_results_drained();
		gaps_on = 1'b1;

		// Full step size, no lookahead
		apply_settings('1, '0);
		run_random(60);
		wait_results_drained();

		// Back to the reset fractions
		apply_settings(sqtu_pkg::LEARN_RATE_RST, sqtu_pkg::DISCOUNT_RST);
		run_random(120);
		wait_results_drained();

		apply_settings(sqtu_pkg::FRAC_W'($urandom), sqtu_pkg::FRAC_W'($urandom));
		run_random(80);
		wait_results_drained();

		// Keep the clock running so that any stray result still shows up
		repeat (20) @(posedge clk);

		$display("Covered %0d transitions under %0d register settings, %0d results checked",
			transitions_sent, settings_used, results_checked);
		$display("Hit %0d saturated updates and %0d clamped action indexes",
			saturated_updates, clamped_actions);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
